// ===== rtl/core/fpsa_pkg.sv =====
// Shared types and constants of the free page stack allocator.
`timescale 1ns / 1ps
`default_nettype none

package fpsa_pkg;

  // Fixed field widths.
  localparam int unsigned ADDR_W   = 56;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FREE_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [ADDR_W-1:0] KERNEL_END_RST = 56'h00_0000_8000_0000;
  localparam logic [ADDR_W-1:0] TOP_ADDR_RST   = 56'h00_0000_8800_0000;

  // Operation codes; code 3 is unused and changes nothing.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_ADDR   = 2'd1;

endpackage

`default_nettype wire

// ===== rtl/core/fpsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module fpsa_ram #(
  parameter int unsigned WIDTH = 44,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                        wr_data_i,
  input  wire logic                                    rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]                        rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/free_page_stack_allocator_unit.sv =====
// Top level of the free page stack allocator.
`timescale 1ns / 1ps
`default_nettype none

// A last-in-first-out store of free physical page numbers held in one
// synchronous RAM of MAX_PAGES entries. Allocate pops the newest page, free
// checks alignment and range and pushes, and initialize refills the store
// with every whole page from the rounded kernel end up to the top address,
// keeping the lowest MAX_PAGES on overflow. Initialize takes constant time:
// it only records a base page and a watermark, and entries below the
// watermark that have not been overwritten read as base plus index. Items
// pass the pending stage, which waits for the stack RAM's registered read,
// and then the output register; a new item is taken in the cycle its
// predecessor's result is accepted. There is no clearing pass after reset.
module free_page_stack_allocator_unit #(
  parameter int unsigned MAX_PAGES  = 32768,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [fpsa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [fpsa_pkg::ADDR_W-1:0]         cfg_data_i,
  // Input item channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [fpsa_pkg::OP_W-1:0]           operation_i,
  input  wire logic [fpsa_pkg::ADDR_W-1:0]         page_address_i,
  // Result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [fpsa_pkg::ADDR_W-1:0]         result_address_o,
  output logic      [fpsa_pkg::STATUS_W-1:0]       status_o,
  output logic      [fpsa_pkg::FREE_W-1:0]         free_pages_o
);

  import fpsa_pkg::*;

  localparam int unsigned PNW = ADDR_W - PAGE_SHIFT;
  localparam int unsigned DW  = $clog2(MAX_PAGES + 1);
  localparam int unsigned AW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  localparam logic [ADDR_W:0] OffsetMask = (ADDR_W + 1)'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [63:0] FirstPageRst64 =
      (64'(KERNEL_END_RST) + ((64'd1 << PAGE_SHIFT) - 64'd1)) >> PAGE_SHIFT;
  localparam logic [PNW:0]   FirstPageRst = FirstPageRst64[PNW:0];
  localparam logic [DW-1:0]  MaxDepth     = DW'(MAX_PAGES);
  localparam logic [PNW:0]   MaxPagesW    = (PNW + 1)'(MAX_PAGES);

  // Configuration: the kernel end is kept only as its rounded first page.
  logic [PNW:0]        fpage_q;
  logic [ADDR_W-1:0]   top_q;
  logic                cfg_xfer;
  logic [ADDR_W:0]     kend_sum;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;
  assign kend_sum    = {1'b0, cfg_data_i} + OffsetMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpage_q <= FirstPageRst;
      top_q   <= TOP_ADDR_RST;
    end else if (cfg_xfer) begin
      if (cfg_index_i == REG_KERNEL_END) begin
        fpage_q <= kend_sum[ADDR_W:PAGE_SHIFT];
      end else if (cfg_index_i == REG_TOP_ADDR) begin
        top_q <= cfg_data_i;
      end
    end
  end

  // Stack state and the two-step pipeline registers.
  logic [DW-1:0]       depth_q, depth_d;
  logic [DW-1:0]       wm_q, wm_d;
  logic [PNW:0]        base_q, base_d;
  logic                pend_q;
  logic                pend_pop_q;
  logic                pend_impl_q;
  logic [AW-1:0]       pend_idx_q;
  status_e             pend_status_q;
  logic [DW-1:0]       pend_depth_q;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_addr_q;
  status_e             out_status_q;
  logic [FREE_W-1:0]   out_free_q;

  logic                in_xfer;
  logic                out_free_slot;
  op_e                 op;
  status_e             status_d;
  logic                pop;
  logic                ram_we;
  logic                ram_re;
  logic [DW-1:0]       depth_m1;
  logic [AW-1:0]       rd_idx;
  logic [AW-1:0]       wr_idx;
  logic [PNW-1:0]      ram_rdata;
  logic                addr_bad;
  logic [PNW-1:0]      addr_pn;
  logic [PNW:0]        top_pn;
  logic [PNW:0]        init_diff;

  assign out_free_slot = ~out_valid_q | out_ready_i;
  assign in_ready_o    = ~pend_q & out_free_slot;
  assign in_xfer       = in_valid_i & in_ready_o;
  assign op            = op_e'(operation_i);

  assign depth_m1  = depth_q - DW'(1);
  assign rd_idx    = depth_m1[AW-1:0];
  assign wr_idx    = depth_q[AW-1:0];
  assign addr_pn   = page_address_i[ADDR_W-1:PAGE_SHIFT];
  assign top_pn    = {1'b0, top_q[ADDR_W-1:PAGE_SHIFT]};
  assign init_diff = top_pn - fpage_q;
  assign addr_bad  = (page_address_i[PAGE_SHIFT-1:0] != '0)
                   || ({1'b0, addr_pn} < fpage_q)
                   || (page_address_i >= top_q);

  // Item decode: stack pointer, watermark and memory access.
  always_comb begin
    depth_d  = depth_q;
    wm_d     = wm_q;
    base_d   = base_q;
    status_d = ST_OK;
    pop      = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    if (in_xfer) begin
      unique case (op)
        OP_ALLOC: begin
          if (depth_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            pop     = 1'b1;
            ram_re  = 1'b1;
            depth_d = depth_m1;
          end
        end
        OP_FREE: begin
          if (addr_bad) begin
            status_d = ST_BAD;
          end else if (depth_q >= MaxDepth) begin
            status_d = ST_FULL;
          end else begin
            ram_we  = 1'b1;
            depth_d = depth_q + DW'(1);
            if (depth_q < wm_q) begin
              wm_d = depth_q;
            end
          end
        end
        OP_INIT: begin
          base_d = fpage_q;
          if (top_pn <= fpage_q) begin
            depth_d = '0;
          end else if (init_diff > MaxPagesW) begin
            depth_d  = MaxDepth;
            status_d = ST_FULL;
          end else begin
            depth_d = init_diff[DW-1:0];
          end
          wm_d = depth_d;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  // Stack pointer and watermark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      wm_q    <= '0;
    end else begin
      depth_q <= depth_d;
      wm_q    <= wm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
  end

  // Stack memory of page numbers.
  fpsa_ram #(
    .WIDTH (PNW),
    .DEPTH (MAX_PAGES)
  ) u_stack_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (wr_idx),
    .wr_data_i (addr_pn),
    .rd_en_i   (ram_re),
    .rd_addr_i (rd_idx),
    .rd_data_o (ram_rdata)
  );

  // Pending stage: holds every item, waiting for the memory read of a pop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pend_pop_q    <= pop;
      pend_impl_q   <= depth_m1 < wm_q;
      pend_idx_q    <= rd_idx;
      pend_status_q <= status_d;
      pend_depth_q  <= depth_d;
    end
  end

  // Result assembly: untouched entries read as base page plus index.
  logic [PNW:0]        impl_pn;
  logic [PNW-1:0]      res_pn;
  logic [DW+FREE_W-1:0] depth_ext;

  assign impl_pn   = base_q + (PNW + 1)'(pend_idx_q);
  assign res_pn    = pend_impl_q ? impl_pn[PNW-1:0] : ram_rdata;
  assign depth_ext = {{FREE_W{1'b0}}, pend_depth_q};

  // Output register; the pending stage only fills it when it is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_addr_q   <= pend_pop_q ? {res_pn, {PAGE_SHIFT{1'b0}}} : '0;
      out_status_q <= pend_status_q;
      out_free_q   <= depth_ext[FREE_W-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign status_o         = out_status_q;
  assign free_pages_o     = out_free_q;

endmodule

`default_nettype wire

// ===== test/page_alloc_checker.sv =====
// Checker of the free page stack allocator: predicts each result and compares it.
`timescale 1ns / 1ps

module page_alloc_checker
  import fpsa_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = 32768,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [ADDR_W-1:0]    page_address_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [ADDR_W-1:0]    result_address_i,
  input  logic [STATUS_W-1:0]  status_i,
  input  logic [FREE_W-1:0]    free_pages_i,
  output int unsigned          pending_o,
  output int unsigned          fail_count_o
);

  localparam int unsigned PN_W      = ADDR_W - PAGE_SHIFT;
  localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    status_e           status;
    logic [FREE_W-1:0] free_pages;
  } page_reply_t;

  // Predicted allocator state: window registers, page number stack and its depth.
  logic [ADDR_W-1:0] kernel_end_q;
  logic [ADDR_W-1:0] top_addr_q;
  logic [PN_W-1:0]   page_numbers [MAX_PAGES];
  int unsigned       depth_q;
  page_reply_t       replies_due [$];
  int unsigned       fail_total;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
    fail_total   = 0;
  end

  // Applies one request to the predicted state and returns the reply it must produce.
  function automatic page_reply_t apply_page_op(input logic [OP_W-1:0]   op,
                                                input logic [ADDR_W-1:0] addr);
    page_reply_t reply;
    logic [63:0] lo_page;
    logic [63:0] hi_page;
    logic [63:0] count;
    logic [63:0] i;
    reply.address = '0;
    reply.status  = ST_OK;
    // The lowest managed page is the kernel end rounded up to a whole page.
    lo_page = (64'(kernel_end_q) + PAGE_MASK) >> PAGE_SHIFT;
    case (op)
      OP_ALLOC: begin
        if (depth_q == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          depth_q--;
          reply.address = ADDR_W'(page_numbers[depth_q]) << PAGE_SHIFT;
        end
      end
      OP_FREE: begin
        if ((64'(addr) & PAGE_MASK) != 0 || 64'(addr) < (lo_page << PAGE_SHIFT) ||
            addr >= top_addr_q) begin
          reply.status = ST_BAD;
        end else if (depth_q >= MAX_PAGES) begin
          reply.status = ST_FULL;
        end else begin
          page_numbers[depth_q] = addr[ADDR_W-1:PAGE_SHIFT];
          depth_q++;
        end
      end
      OP_INIT: begin
        // Refill with every whole page of the window, keeping the lowest ones on overflow.
        hi_page = 64'(top_addr_q) >> PAGE_SHIFT;
        count   = (hi_page > lo_page) ? hi_page - lo_page : 64'd0;
        if (count > MAX_PAGES) begin
          count        = MAX_PAGES;
          reply.status = ST_FULL;
        end
        for (i = 0; i < count; i++) begin
          page_numbers[i] = PN_W'(lo_page + i);
        end
        depth_q = int'(count);
      end
      default: begin
      end
    endcase
    reply.free_pages = FREE_W'(depth_q);
    return reply;
  endfunction

  // Watch all three channels; results are checked before a new request is predicted.
  always @(posedge clk_i) begin
    page_reply_t want;
    if (!rst_ni) begin
      kernel_end_q = KERNEL_END_RST;
      top_addr_q   = TOP_ADDR_RST;
      depth_q      = 0;
      replies_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_KERNEL_END) begin
          kernel_end_q = cfg_data_i;
        end else if (cfg_index_i == REG_TOP_ADDR) begin
          top_addr_q = cfg_data_i;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $error("result transfer with no request outstanding: address %h status %0d",
                 result_address_i, status_i);
          fail_total++;
        end else begin
          want = replies_due.pop_front();
          if (result_address_i !== want.address) begin
            $error("result_address expected %h actual %h", want.address, result_address_i);
            fail_total++;
          end
          if (status_i !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status_i);
            fail_total++;
          end
          if (free_pages_i !== want.free_pages) begin
            $error("free_pages expected %0d actual %0d", want.free_pages, free_pages_i);
            fail_total++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        replies_due.push_back(apply_page_op(operation_i, page_address_i));
      end
    end
    pending_o    <= replies_due.size();
    fail_count_o <= fail_total;
  end

endmodule

// ===== test/tb_free_page_stack_allocator_unit.sv =====
// Testbench top of the free page stack allocator: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_free_page_stack_allocator_unit;
  import fpsa_pkg::*;

  localparam int unsigned MAX_PAGES       = 32768;
  localparam int unsigned PAGE_SHIFT      = 12;
  localparam int unsigned PHASES          = 9;
  localparam int unsigned ITEMS_PER_PHASE = 92;
  localparam logic [63:0] PAGE_MASK       = (64'd1 << PAGE_SHIFT) - 64'd1;
  localparam logic [63:0] PAGE_LIMIT      = 64'd1 << (ADDR_W - PAGE_SHIFT);

  // Operation code with no function, and register indexes that map to nothing.
  localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAP_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAP_B = 2'd3;

  typedef enum int unsigned {
    FREE_GOOD,
    FREE_UNALIGNED,
    FREE_BELOW,
    FREE_AT_TOP,
    FREE_ABOVE,
    FREE_NOISE
  } free_kind_e;

  logic                 clk_i;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = REG_KERNEL_END;
  logic [ADDR_W-1:0]    cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic [OP_W-1:0]      operation_i    = OP_ALLOC;
  logic [ADDR_W-1:0]    page_address_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [ADDR_W-1:0]    result_address_o;
  logic [STATUS_W-1:0]  status_o;
  logic [FREE_W-1:0]    free_pages_o;

  int unsigned          reply_backlog;
  int unsigned          mismatch_total;
  int unsigned          tx_gap_pct   = 25;
  int unsigned          rx_stall_pct = 47;
  logic [ADDR_W-1:0]    window_kernel = KERNEL_END_RST;
  logic [ADDR_W-1:0]    window_top    = TOP_ADDR_RST;

  free_page_stack_allocator_unit #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .page_address_i  (page_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_address_o(result_address_o),
    .status_o        (status_o),
    .free_pages_o    (free_pages_o)
  );

  page_alloc_checker #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .operation_i     (operation_i),
    .page_address_i  (page_address_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_address_i(result_address_o),
    .status_i        (status_o),
    .free_pages_i    (free_pages_o),
    .pending_o       (reply_backlog),
    .fail_count_o    (mismatch_total)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The result receiver stalls at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Run guard in case the block stops making progress.
  initial begin
    #10ms;
    $display("free_page_stack_allocator_unit test failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] rand56();
    return ADDR_W'(rand64());
  endfunction

  // Chooses an address of the requested class against the current page window.
  function automatic logic [ADDR_W-1:0] pick_page_address(input free_kind_e kind);
    logic [63:0]       lo_pg;
    logic [63:0]       end_pg;
    logic [63:0]       span;
    logic [63:0]       pg;
    logic [ADDR_W-1:0] addr;
    lo_pg  = (64'(window_kernel) + PAGE_MASK) >> PAGE_SHIFT;
    // Pages whose base address lies below the top address.
    end_pg = (64'(window_top) + PAGE_MASK) >> PAGE_SHIFT;
    span   = (end_pg > lo_pg) ? end_pg - lo_pg : 64'd0;
    addr   = rand56();
    case (kind)
      FREE_GOOD, FREE_UNALIGNED: begin
        if (span != 0) begin
          case ($urandom_range(0, 3))
            0:       pg = lo_pg;
            1:       pg = end_pg - 64'd1;
            default: pg = lo_pg + rand64() % span;
          endcase
          addr = ADDR_W'(pg << PAGE_SHIFT);
        end
        if (kind == FREE_UNALIGNED) begin
          addr[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
        end
      end
      FREE_BELOW: begin
        if (lo_pg != 0) begin
          pg   = $urandom_range(0, 1) ? lo_pg - 64'd1 : rand64() % lo_pg;
          addr = ADDR_W'(pg << PAGE_SHIFT);
        end
      end
      FREE_AT_TOP: addr = window_top;
      FREE_ABOVE: begin
        if (end_pg < PAGE_LIMIT) begin
          pg   = $urandom_range(0, 1) ? end_pg : end_pg + rand64() % (PAGE_LIMIT - end_pg);
          addr = ADDR_W'(pg << PAGE_SHIFT);
        end
      end
      default: begin
      end
    endcase
    return addr;
  endfunction

  // Offers one request, with a random gap first, and returns once it is transferred.
  task automatic offer_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_gap_pct);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    page_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Holds one register write until it is transferred; valid is left high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Drains all outstanding requests, then reprograms the page window.
  task automatic program_window(input logic [ADDR_W-1:0] kernel_end,
                                input logic [ADDR_W-1:0] top_addr,
                                input bit                touch_unmapped);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reply_backlog != 0);
    write_reg(REG_KERNEL_END, kernel_end);
    write_reg(REG_TOP_ADDR, top_addr);
    if (touch_unmapped) begin
      write_reg(REG_UNMAP_A, '1);
      write_reg(REG_UNMAP_B, '1);
    end
    cfg_valid_i   <= 1'b0;
    window_kernel  = kernel_end;
    window_top     = top_addr;
  endtask

  // Stimulus: directed corner cases, then random phases over several windows.
  initial begin
    int unsigned       phase;
    int unsigned       roll;
    int unsigned       waited;
    logic [ADDR_W-1:0] kern;
    logic [ADDR_W-1:0] topa;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window: empty store, range and alignment checks, then a full refill.
    offer_request(OP_ALLOC, '0);
    offer_request(OP_FREE, 56'h0000_0000_8800_0000);
    offer_request(OP_FREE, 56'h0000_0000_87ff_f000);
    offer_request(OP_FREE, 56'h0000_0000_8000_0800);
    offer_request(OP_FREE, 56'h0000_0000_7fff_f000);
    offer_request(OP_FREE, 56'h0000_0000_8000_0000);
    offer_request(OP_ALLOC, '1);
    offer_request(OP_ALLOC, '0);
    offer_request(OP_UNUSED, '1);
    offer_request(OP_INIT, '0);
    offer_request(OP_FREE, 56'h0000_0000_8000_0000);
    offer_request(OP_ALLOC, '0);
    offer_request(OP_FREE, 56'hff_ffff_ffff_f000);

    // Three pages from page zero: drain past empty and hand page zero back.
    program_window('0, 56'h3000, 1'b1);
    offer_request(OP_INIT, '1);
    repeat (4) offer_request(OP_ALLOC, '0);
    offer_request(OP_FREE, '0);
    offer_request(OP_ALLOC, '0);

    // Kernel end above the top address leaves an empty range.
    program_window(56'h10_0000, 56'h8_0000, 1'b0);
    offer_request(OP_INIT, '0);
    offer_request(OP_FREE, 56'h9_0000);

    // Both registers at their maximum: nothing is managed.
    program_window('1, '1, 1'b0);
    offer_request(OP_INIT, '0);
    offer_request(OP_FREE, 56'hff_ffff_ffff_f000);

    // Whole address space: the refill overflows the store.
    program_window('0, '1, 1'b0);
    offer_request(OP_INIT, '0);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase / 3)
        0:       begin tx_gap_pct = 25; rx_stall_pct = 47; end
        1:       begin tx_gap_pct = 47; rx_stall_pct = 25; end
        default: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
      endcase
      case (phase)
        0: begin kern = KERNEL_END_RST; topa = TOP_ADDR_RST; end
        1: begin kern = '0; topa = 56'h2_0000; end
        2: begin kern = 56'h1234_5001; topa = 56'h1234_5001 + 56'd50 * 56'd4096 + 56'h7ff; end
        4: begin kern = '0; topa = '1; end
        5: begin kern = '1; topa = '1; end
        7: begin kern = rand56(); topa = rand56(); end
        default: begin
          // A window of up to 400 whole pages at a random magnitude.
          kern = rand56() >> $urandom_range(1, 55);
          if ($urandom_range(0, 1)) kern[PAGE_SHIFT-1:0] = '0;
          topa = kern + ADDR_W'($urandom_range(0, 400)) * 56'd4096 +
                 ADDR_W'($urandom_range(0, 4095));
        end
      endcase
      program_window(kern, topa, 1'b0);

      // Each phase starts from a freshly filled store.
      offer_request(OP_INIT, rand56());
      repeat (ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)       offer_request(OP_INIT, rand56());
        else if (roll < 43) offer_request(OP_ALLOC, rand56());
        else if (roll < 78) offer_request(OP_FREE, pick_page_address(FREE_GOOD));
        else if (roll < 82) offer_request(OP_FREE, pick_page_address(FREE_UNALIGNED));
        else if (roll < 86) offer_request(OP_FREE, pick_page_address(FREE_BELOW));
        else if (roll < 89) offer_request(OP_FREE, pick_page_address(FREE_AT_TOP));
        else if (roll < 92) offer_request(OP_FREE, pick_page_address(FREE_ABOVE));
        else if (roll < 96) offer_request(OP_FREE, pick_page_address(FREE_NOISE));
        else                offer_request(OP_UNUSED, rand56());
      end
    end

    // Let the last results drain, then allow for the block's latency.
    in_valid_i <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (reply_backlog != 0 && waited < 20000);
    repeat (4) @(posedge clk_i);
    if (reply_backlog != 0) begin
      $error("%0d results never arrived", reply_backlog);
    end

    if (mismatch_total == 0 && reply_backlog == 0) begin
      $display("free_page_stack_allocator_unit test passed");
    end else begin
      $display("free_page_stack_allocator_unit test failed");
    end
    $finish;
  end

endmodule
